>>> rtl/core/jav_pkg.sv
`timescale 1ns / 1ps

package jav_pkg;

  localparam int DIV_W = 54;

  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_SEED = 2'd2;

  localparam logic [19:0] US_PER_S       = 20'd1000000;
  localparam logic [19:0] PERIOD_MIN_US  = 20'd100;
  localparam logic [19:0] PERIOD_DEF_US  = 20'd8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       latch;
    logic       mul;
    logic       div_start;
    logic       fin;
    logic       emit;
    logic [1:0] phase;
  } dp_cmd_t;

  typedef struct packed {
    logic compute;
    logic div_done;
  } dp_status_t;

  // saturate to signed 32 bits; bit 32 flags a hit
  function automatic logic [32:0] sat32(input logic signed [DIV_W:0] x);
    logic [32:0] r;
    if (x > $signed({{(DIV_W-31){1'b0}}, 32'h7fffffff})) begin
      r = {1'b1, 32'h7fffffff};
    end else if (x < $signed({{(DIV_W-31){1'b1}}, 32'h80000000})) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] x,
                                                   input logic [30:0] lim);
    logic signed [32:0] xs;
    logic signed [32:0] ls;
    logic signed [31:0] r;
    xs = {x[31], x};
    ls = {2'b00, lim};
    if (xs > ls) begin
      r = {1'b0, lim};
    end else if (xs < -ls) begin
      r = 32'(-ls);
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/joint_accel_velocity_limiter.sv
`timescale 1ns / 1ps
// Per-joint acceleration and velocity limited position setpoint filter.
// Input channel (in_valid / in_stall) carries one request: a step, a limit
// load or a position seed for one joint. Output channel (out_valid /
// out_stall) returns one result per request: joint, position, velocity and
// a saturation flag. cfg_wr_en / cfg_wr_data write the limiter enable bit.
// One request is worked on at a time. A step with the limiter enabled runs
// four multiply and divide phases: both divisions by the period go through a
// restoring divider, one quotient bit per cycle over 54 bits; both divisions
// by one million use a reciprocal multiply with a remainder fix-up. Any other
// request goes from the check state straight to the emit state. The next
// request is taken in the cycle after the result is loaded.
// in_stall stays high from accept until the result has been loaded into the
// output register; the result then waits there for as long as out_stall is
// high, and the block takes the next request meanwhile.
// Synchronous reset clears all joint positions, velocities and limits, the
// enable bit, the controller state and the result valid flag.

module joint_accel_velocity_limiter import jav_pkg::*; #(
  parameter int JOINT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_joint,
  input  logic signed [31:0] in_target_position,
  input  logic               in_target_valid,
  input  logic [23:0]        in_period_us,
  input  logic [30:0]        in_max_accel,
  input  logic [30:0]        in_max_vel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_joint_out,
  output logic signed [31:0] out_position_out,
  output logic signed [31:0] out_velocity_out,
  output logic               out_saturated
);

  dp_cmd_t    cmd;
  dp_status_t status;

  jav_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  jav_dp #(.JOINT_COUNT(JOINT_COUNT)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_command         (in_command),
    .in_joint           (in_joint),
    .in_target_position (in_target_position),
    .in_target_valid    (in_target_valid),
    .in_period_us       (in_period_us),
    .in_max_accel       (in_max_accel),
    .in_max_vel         (in_max_vel),
    .out_joint_out      (out_joint_out),
    .out_position_out   (out_position_out),
    .out_velocity_out   (out_velocity_out),
    .out_saturated      (out_saturated)
  );

endmodule

>>> rtl/core/jav_div.sv
`timescale 1ns / 1ps

module jav_div import jav_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic [19:0]             divisor,
  output logic                    done,
  output logic signed [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [19:0]      rem_r, rem_nxt;
  logic [19:0]      dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r, neg_r;
  logic [20:0]      shifted, trial;
  logic             ge;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign ge      = !trial[20];
  assign rem_nxt = ge ? trial[19:0] : shifted[19:0];
  assign quo_nxt = {quo_r[DIV_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[DIV_W-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

>>> rtl/core/jav_ctrl.sv
`timescale 1ns / 1ps

module jav_ctrl import jav_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] phase_r;
  logic       out_valid_r;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = status.compute ? ST_MUL : ST_EMIT;
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (status.div_done) state_nxt = ST_FIN;
      ST_FIN:    state_nxt = (phase_r == 2'd3) ? ST_EMIT : ST_MUL;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.phase     = phase_r;
    in_stall      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      ST_MUL:    cmd.mul       = 1'b1;
      ST_DSTART: cmd.div_start = 1'b1;
      ST_FIN:    cmd.fin       = 1'b1;
      ST_EMIT:   cmd.emit      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CHECK) phase_r <= '0;
      else if (cmd.fin)        phase_r <= phase_r + 1'b1;
      if (cmd.emit)            out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/jav_dp.sv
`timescale 1ns / 1ps

module jav_dp import jav_pkg::*; #(
  parameter int JOINT_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_joint,
  input  logic signed [31:0] in_target_position,
  input  logic               in_target_valid,
  input  logic [23:0]        in_period_us,
  input  logic [30:0]        in_max_accel,
  input  logic [30:0]        in_max_vel,
  output logic [2:0]         out_joint_out,
  output logic signed [31:0] out_position_out,
  output logic signed [31:0] out_velocity_out,
  output logic               out_saturated
);

  localparam int DEPTH = (JOINT_COUNT < 8) ? JOINT_COUNT : 8;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // divide by 1000000 as 64 * 15625: drop 6 bits, multiply the top 32 bits
  // by floor(2^45 / 15625), then raise the estimate (low by at most 2)
  localparam logic [31:0] RECIP    = 32'd2251799813;
  localparam logic [15:0] ODD_DIV  = 16'd15625;
  localparam logic [15:0] ODD_DIV2 = 16'd31250;

  logic signed [31:0] pos_r [DEPTH];
  logic signed [31:0] vel_r [DEPTH];
  logic [30:0]        alim_r [DEPTH];
  logic [30:0]        vlim_r [DEPTH];

  logic               enable_r;
  logic [IW-1:0]      idx, idx_r;
  logic               in_range;
  logic [2:0]         joint_r;
  logic signed [31:0] p_r, w_r, t_r, acc_r, q_r, v_r;
  logic [19:0]        per_r;
  logic [30:0]        alim_c_r, vlim_c_r, new_alim_r, new_vlim_r;
  logic               compute_r, wr_state_r, wr_lim_r, hit_r;
  logic [19:0]        per_fix;

  logic signed [32:0]       mul_a;
  logic signed [20:0]       mul_b;
  logic signed [DIV_W-1:0]  prod_r;
  logic                     div_done;
  logic signed [DIV_W-1:0]  quo;
  logic signed [DIV_W:0]    fin_sum;
  logic [32:0]              fin_sat;
  logic signed [31:0]       fin_clamped;

  logic                     start_var, start_const;
  logic                     done_var;
  logic signed [DIV_W-1:0]  quo_var, quo_const;

  logic [DIV_W-1:0]         cd_mag;
  logic [44:0]              cd_y_r;
  logic [31:0]              cd_q_r;
  logic [15:0]              cd_rem_r;
  logic                     cd_neg_r, cd_mul_v_r, cd_est_v_r, cd_rem_v_r, cd_done_r;
  logic [63:0]              cd_est;
  logic [45:0]              cd_back;
  logic [44:0]              cd_diff;
  logic [DIV_W-1:0]         cd_q_ext;

  assign idx      = in_joint[IW-1:0];
  assign in_range = {29'd0, in_joint} < JOINT_COUNT;
  assign per_fix  = (in_period_us > {4'd0, PERIOD_MIN_US} &&
                     in_period_us < {4'd0, US_PER_S}) ? in_period_us[19:0] : PERIOD_DEF_US;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      joint_r    <= in_joint;
      idx_r      <= idx;
      p_r        <= pos_r[idx];
      w_r        <= vel_r[idx];
      alim_c_r   <= alim_r[idx];
      vlim_c_r   <= vlim_r[idx];
      t_r        <= in_target_valid ? in_target_position : pos_r[idx];
      per_r      <= per_fix;
      new_alim_r <= in_max_accel;
      new_vlim_r <= in_max_vel;
      hit_r      <= 1'b0;
      compute_r  <= in_range && in_command == CMD_STEP && enable_r;
      wr_state_r <= in_range && (in_command == CMD_SEED ||
                                 (in_command == CMD_STEP && enable_r));
      wr_lim_r   <= in_range && in_command == CMD_LOAD;
      if (!in_range) begin
        q_r <= '0;
        v_r <= '0;
      end else if (in_command == CMD_SEED) begin
        q_r <= in_target_valid ? in_target_position : '0;
        v_r <= '0;
      end else if (in_command == CMD_STEP) begin
        q_r <= in_target_valid ? in_target_position : pos_r[idx];
        v_r <= vel_r[idx];
      end else begin
        q_r <= pos_r[idx];
        v_r <= vel_r[idx];
      end
    end else if (cmd.fin) begin
      hit_r <= hit_r | fin_sat[32];
      case (cmd.phase)
        2'd0: acc_r <= fin_sat[31:0];
        2'd1: acc_r <= fin_clamped;
        2'd2: begin
          acc_r <= fin_clamped;
          v_r   <= fin_clamped;
        end
        default: q_r <= fin_sat[31:0];
      endcase
    end
  end

  always_comb begin
    case (cmd.phase)
      2'd0:    mul_a = {t_r[31], t_r} - {p_r[31], p_r};
      2'd1:    mul_a = {acc_r[31], acc_r} - {w_r[31], w_r};
      default: mul_a = {acc_r[31], acc_r};
    endcase
    mul_b = cmd.phase[1] ? $signed({1'b0, per_r}) : $signed({1'b0, US_PER_S});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= mul_a * mul_b;
  end

  assign start_var   = cmd.div_start && !cmd.phase[1];
  assign start_const = cmd.div_start && cmd.phase[1];

  jav_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_var),
    .dividend (prod_r),
    .divisor  (per_r),
    .done     (done_var),
    .quotient (quo_var)
  );

  assign cd_mag   = prod_r[DIV_W-1] ? DIV_W'(-prod_r) : prod_r;
  assign cd_est   = cd_y_r[44:13] * RECIP;
  assign cd_back  = cd_q_r * ODD_DIV;
  assign cd_diff  = cd_y_r - cd_back[44:0];
  assign cd_q_ext = {{(DIV_W-32){1'b0}}, cd_q_r};
  assign quo_const = cd_neg_r ? -$signed(cd_q_ext) : $signed(cd_q_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_mul_v_r <= 1'b0;
      cd_est_v_r <= 1'b0;
      cd_rem_v_r <= 1'b0;
      cd_done_r  <= 1'b0;
    end else begin
      cd_mul_v_r <= start_const;
      cd_est_v_r <= cd_mul_v_r;
      cd_rem_v_r <= cd_est_v_r;
      cd_done_r  <= cd_rem_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_const) begin
      cd_y_r   <= cd_mag[50:6];
      cd_neg_r <= prod_r[DIV_W-1];
    end
    if (cd_mul_v_r) begin
      cd_q_r <= cd_est[63:32];
    end else if (cd_rem_v_r) begin
      if (cd_rem_r >= ODD_DIV2)     cd_q_r <= cd_q_r + 32'd2;
      else if (cd_rem_r >= ODD_DIV) cd_q_r <= cd_q_r + 32'd1;
    end
    if (cd_est_v_r) cd_rem_r <= cd_diff[15:0];
  end

  assign div_done = cmd.phase[1] ? cd_done_r : done_var;
  assign quo      = cmd.phase[1] ? quo_const : quo_var;

  always_comb begin
    case (cmd.phase)
      2'd2:    fin_sum = {quo[DIV_W-1], quo} + (DIV_W+1)'(w_r);
      2'd3:    fin_sum = {quo[DIV_W-1], quo} + (DIV_W+1)'(p_r);
      default: fin_sum = {quo[DIV_W-1], quo};
    endcase
    fin_sat     = sat32(fin_sum);
    fin_clamped = clamp_sym(fin_sat[31:0], (cmd.phase == 2'd1) ? alim_c_r : vlim_c_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        pos_r[i]  <= '0;
        vel_r[i]  <= '0;
        alim_r[i] <= '0;
        vlim_r[i] <= '0;
      end
    end else if (cmd.emit) begin
      if (wr_state_r) begin
        pos_r[idx_r] <= q_r;
        vel_r[idx_r] <= v_r;
      end
      if (wr_lim_r) begin
        alim_r[idx_r] <= new_alim_r;
        vlim_r[idx_r] <= new_vlim_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_joint_out    <= joint_r;
      out_position_out <= q_r;
      out_velocity_out <= v_r;
      out_saturated    <= hit_r;
    end
  end

  assign status.compute  = compute_r;
  assign status.div_done = div_done;

endmodule

>>> rtl/core/jav_checker.sv
`timescale 1ns / 1ps

module jav_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_position_out
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_position_out))
    else $error("stalled result changed");

endmodule

bind joint_accel_velocity_limiter jav_checker u_jav_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_position_out (out_position_out)
);

>>> tb/sv/joint_accel_velocity_limiter_checker.sv
`timescale 1ns / 1ps

module joint_accel_velocity_limiter_checker import jav_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [2:0]         in_joint,
  input  logic signed [31:0] in_target_position,
  input  logic               in_target_valid,
  input  logic [23:0]        in_period_us,
  input  logic [30:0]        in_max_accel,
  input  logic [30:0]        in_max_vel,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_joint_out,
  input  logic signed [31:0] out_position_out,
  input  logic signed [31:0] out_velocity_out,
  input  logic               out_saturated,
  output int                 errors,
  output int                 pending,
  output int                 limited_steps,
  output int                 sat_results
);

  typedef struct {
    logic [2:0]         joint;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               sat;
  } setpoint_t;

  setpoint_t          setpoint_q[$];
  logic signed [31:0] joint_pos[8];
  logic signed [31:0] joint_vel[8];
  logic [30:0]        accel_lim[8];
  logic [30:0]        vel_lim[8];
  logic               limit_on;

  assign pending = setpoint_q.size();

  function automatic longint clip32(input longint x, inout bit hit);
    if (x > longint'(32'sh7fffffff)) begin
      hit = 1'b1;
      return longint'(32'sh7fffffff);
    end
    if (x < -longint'(64'h80000000)) begin
      hit = 1'b1;
      return -longint'(64'h80000000);
    end
    return x;
  endfunction

  function automatic longint clamp_lim(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  task automatic predict_setpoint();
    setpoint_t s;
    longint    p, w, t, per, vt, a, v, q;
    bit        hit;
    int        j;
    j = in_joint;
    p = joint_pos[j];
    w = joint_vel[j];
    hit = 1'b0;
    s.joint = in_joint;
    s.pos = joint_pos[j];
    s.vel = joint_vel[j];
    s.sat = 1'b0;
    case (in_command)
      CMD_LOAD: begin
        accel_lim[j] = in_max_accel;
        vel_lim[j] = in_max_vel;
      end
      CMD_SEED: begin
        joint_pos[j] = in_target_valid ? in_target_position : 32'sd0;
        joint_vel[j] = 32'sd0;
        s.pos = joint_pos[j];
        s.vel = 32'sd0;
      end
      CMD_STEP: begin
        if (!limit_on) begin
          if (in_target_valid) s.pos = in_target_position;
        end else begin
          per = in_period_us;
          if (!(per > longint'(PERIOD_MIN_US) && per < longint'(US_PER_S)))
            per = longint'(PERIOD_DEF_US);
          t = in_target_valid ? longint'(in_target_position) : p;
          vt = clip32((t - p) * longint'(US_PER_S) / per, hit);
          a = clip32((vt - w) * longint'(US_PER_S) / per, hit);
          a = clamp_lim(a, longint'(accel_lim[j]));
          v = clip32(w + a * per / longint'(US_PER_S), hit);
          v = clamp_lim(v, longint'(vel_lim[j]));
          q = clip32(p + v * per / longint'(US_PER_S), hit);
          joint_pos[j] = q[31:0];
          joint_vel[j] = v[31:0];
          s.pos = q[31:0];
          s.vel = v[31:0];
          s.sat = hit;
          limited_steps++;
          if (hit) sat_results++;
        end
      end
      default: begin
      end
    endcase
    setpoint_q.insert(setpoint_q.size(), s);
  endtask

  task automatic compare_setpoint();
    setpoint_t s;
    if (setpoint_q.size() == 0) begin
      $display("%0t: unexpected result joint %0d pos %h vel %h sat %b", $time,
               out_joint_out, out_position_out, out_velocity_out, out_saturated);
      errors++;
    end else begin
      s = setpoint_q.pop_front();
      if (out_joint_out !== s.joint) begin
        $display("%0t: joint expected %0d actual %0d", $time, s.joint, out_joint_out);
        errors++;
      end
      if (out_position_out !== s.pos) begin
        $display("%0t: position expected %h actual %h", $time, s.pos, out_position_out);
        errors++;
      end
      if (out_velocity_out !== s.vel) begin
        $display("%0t: velocity expected %h actual %h", $time, s.vel, out_velocity_out);
        errors++;
      end
      if (out_saturated !== s.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, s.sat, out_saturated);
        errors++;
      end
    end
  endtask

  initial begin
    errors = 0;
    limited_steps = 0;
    sat_results = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        joint_pos[i] = '0;
        joint_vel[i] = '0;
        accel_lim[i] = '0;
        vel_lim[i] = '0;
      end
      limit_on = 1'b0;
      setpoint_q.delete();
    end else begin
      if (cfg_wr_en) limit_on = cfg_wr_data;
      if (in_valid && !in_stall) predict_setpoint();
      if (out_valid && !out_stall) compare_setpoint();
    end
  end

endmodule

>>> tb/sv/joint_accel_velocity_limiter_test.sv
`timescale 1ns / 1ps

module joint_accel_velocity_limiter_test import jav_pkg::*;;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = CMD_STEP;
  logic [2:0]         in_joint = '0;
  logic signed [31:0] in_target_position = '0;
  logic               in_target_valid = 1'b0;
  logic [23:0]        in_period_us = '0;
  logic [30:0]        in_max_accel = '0;
  logic [30:0]        in_max_vel = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_joint_out;
  logic signed [31:0] out_position_out;
  logic signed [31:0] out_velocity_out;
  logic               out_saturated;

  int errors, pending, limited_steps, sat_results, requests;
  bit idle_on;
  bit long_hold;
  bit hold_done;

  always #5 clk = ~clk;

  joint_accel_velocity_limiter #(.JOINT_COUNT(8)) u_dut (.*);

  joint_accel_velocity_limiter_checker u_chk (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall, .in_command,
    .in_joint, .in_target_position, .in_target_valid, .in_period_us,
    .in_max_accel, .in_max_vel, .out_valid, .out_stall, .out_joint_out,
    .out_position_out, .out_velocity_out, .out_saturated,
    .errors, .pending, .limited_steps, .sat_results
  );

  task automatic send(input logic [1:0] cmd, input logic [2:0] j,
                      input logic [31:0] tgt, input logic tv, input logic [23:0] per,
                      input logic [30:0] acc, input logic [30:0] vel);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_joint <= j;
    in_target_position <= tgt;
    in_target_valid <= tv;
    in_period_us <= per;
    in_max_accel <= acc;
    in_max_vel <= vel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests++;
  endtask

  task automatic step(input logic [2:0] j, input logic [31:0] tgt, input logic tv,
                      input logic [23:0] per);
    send(CMD_STEP, j, tgt, tv, per, 31'($urandom), 31'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_enable(input logic en);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [30:0] rand_limit();
    logic [30:0] l;
    l = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 32'h03ffffff));
    return (l == 0) ? 31'd1 : l;
  endfunction

  function automatic logic [23:0] rand_period();
    case ($urandom_range(0, 9))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 101));
      2: return 24'($urandom_range(999999, 1000001));
      default: return 24'($urandom_range(101, 20000));
    endcase
  endfunction

  task automatic random_request();
    int          r;
    logic [31:0] tgt;
    r = $urandom_range(0, 99);
    tgt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00ffffff) - 32'h007fffff;
    if (r < 8) send(CMD_LOAD, 3'($urandom), $urandom, 1'($urandom), 24'($urandom),
                     rand_limit(), rand_limit());
    else if (r < 14) send(CMD_SEED, 3'($urandom), tgt, $urandom_range(0, 5) != 0,
                          24'($urandom), 31'($urandom), 31'($urandom));
    else if (r < 16) send(CMD_SPARE, 3'($urandom), $urandom, 1'($urandom), 24'($urandom),
                          31'($urandom), 31'($urandom));
    else step(3'($urandom), tgt, $urandom_range(0, 7) != 0, rand_period());
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    requests = 0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_enable(1'b1);
    send(CMD_LOAD, 3'd0, '0, 1'b1, '0, 31'h7fffffff, 31'h7fffffff);
    step(3'd0, 32'h7fffffff, 1'b1, 24'd1000);
    step(3'd0, 32'h80000000, 1'b1, 24'd101);
    step(3'd0, 32'h12345678, 1'b0, 24'd0);
    step(3'd0, 32'h00010000, 1'b1, 24'd100);
    step(3'd0, 32'h00020000, 1'b1, 24'd999999);
    step(3'd0, 32'h00030000, 1'b1, 24'd1000000);
    step(3'd0, 32'h00040000, 1'b1, 24'hffffff);
    send(CMD_LOAD, 3'd1, '0, 1'b0, '0, 31'd1, 31'd1);
    step(3'd1, 32'h00100000, 1'b1, 24'd8000);
    step(3'd1, 32'hfff00000, 1'b1, 24'd500);
    step(3'd2, 32'h7fff0000, 1'b1, 24'd8000);
    send(CMD_SEED, 3'd3, 32'h80000000, 1'b1, '0, '0, '0);
    send(CMD_SEED, 3'd4, 32'h7fffffff, 1'b0, '0, '0, '0);
    send(CMD_LOAD, 3'd3, '0, 1'b1, '0, 31'h00100000, 31'h00080000);
    step(3'd3, 32'h7fffffff, 1'b1, 24'd200);
    send(CMD_SPARE, 3'd7, 32'hffffffff, 1'b1, 24'hffffff, 31'h7fffffff, 31'h7fffffff);
    step(3'd7, 32'h00010000, 1'b1, 24'd8000);
    drain();

    write_enable(1'b0);
    step(3'd0, 32'h7fffffff, 1'b1, 24'd8000);
    step(3'd3, 32'h00050000, 1'b0, 24'd8000);
    repeat (80) random_request();
    drain();

    write_enable(1'b1);
    for (int i = 0; i < 8; i++)
      send(CMD_LOAD, 3'(i), '0, 1'b1, '0, rand_limit(), rand_limit());
    long_hold = 1'b1;
    repeat (450) random_request();
    drain();

    write_enable(1'b0);
    repeat (60) random_request();
    drain();

    write_enable(1'b1);
    idle_on = 1'b0;
    repeat (120) random_request();
    drain();

    $display("Covered %0d requests, %0d limited steps, %0d with saturation.",
             requests, limited_steps, sat_results);
    $display("Enable toggled across phases, with idle, stall and long back-pressure.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/jav_pkg.sv
rtl/core/jav_div.sv
rtl/core/jav_ctrl.sv
rtl/core/jav_dp.sv
rtl/core/joint_accel_velocity_limiter.sv
rtl/core/jav_checker.sv
tb/sv/joint_accel_velocity_limiter_checker.sv
tb/sv/joint_accel_velocity_limiter_test.sv
